/* rtl/wft_pkg.sv */
// Package with the shared types, constants and character classes of the word frequency table.
`default_nettype none
package wft_pkg;

	localparam int KEY_CHARS = 25;
	localparam int KEY_BITS  = 8 * KEY_CHARS;

	typedef enum logic {
		KIND_BYTE = 1'b0,
		KIND_END  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_HIT  = 2'd0,
		ST_NEW  = 2'd1,
		ST_DROP = 2'd2
	} status_t;

	// Control broadcast to every character cell of the token row.
	typedef struct packed {
		logic       clear;
		logic       load;
		logic [7:0] data;
	} cell_ctl_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c inside {[8'h61:8'h7a]}) || (c inside {[8'h41:8'h5a]});
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_letter(c) || (c inside {[8'h30:8'h39]});
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c inside {[8'h09:8'h0d]});
	endfunction

	// Trailing characters removed once: : ! , . ? ) "
	function automatic logic is_strip(input logic [7:0] c);
		return c inside {8'h3a, 8'h21, 8'h2c, 8'h2e, 8'h3f, 8'h29, 8'h22};
	endfunction

endpackage
`default_nettype wire

/* rtl/word_frequency_table.sv */
// Top level of the word frequency table: token row, table scan and result register.
//
// Usage: text enters one beat at a time on the input channel (in_valid, in_ready,
// kind, text_byte). A beat with kind 0 carries one text byte; a beat with kind 1
// marks end of text, finishes the pending token and then empties the table.
// Whitespace or end of text closes a token; a token that survives the filters
// produces exactly one result beat on the output channel (out_valid, out_ready,
// status, slot, occurrences, chars_*, word_length). Other beats produce none.
// A byte inside a token is accepted whenever the block is idle. A closing beat
// that keeps a word starts a scan of the table memory at one entry per cycle over
// the filled entries, bounded by the single read port of the table memory; the
// entry is then written and the result registered.
// The input is not taken during a scan. The result sits in an output register,
// so the next text bytes are accepted while a result waits. When the receiver
// stalls with a result waiting and a new word is finished, the block holds
// that word in its final state until the register frees up.
// Reset clears the token state, the fill level and all handshake state; the
// table contents are not cleared, since entries above the fill level are never
// read. No clearing pass is needed.
`default_nettype none
module word_frequency_table #(
	parameter int TABLE_ENTRIES  = 1024,
	parameter int MAX_WORD_CHARS = 25,
	parameter int COUNT_BITS     = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [7:0]  text_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [9:0]       slot,
	output logic [31:0]      occurrences,
	output logic [63:0]      chars_low,
	output logic [63:0]      chars_mid,
	output logic [63:0]      chars_high,
	output logic [7:0]       char_last,
	output logic [4:0]       word_length
);
	import wft_pkg::*;

	localparam int SLOTS = MAX_WORD_CHARS + 1;
	localparam int LW    = $clog2(SLOTS + 1);
	localparam int FW    = $clog2(TABLE_ENTRIES + 1);
	localparam int AW    = TABLE_ENTRIES > 1 ? $clog2(TABLE_ENTRIES) : 1;
	localparam int RW    = KEY_BITS + COUNT_BITS;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_WRITE = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	// Token state.
	logic [LW-1:0] len_q;
	logic          ovf_q;
	logic          dot_q;
	logic          inner_bad_q;
	logic [7:0]    last_q;

	// Word under lookup.
	logic [KEY_BITS-1:0]   key_q;
	logic [LW-1:0]         wlen_q;
	logic                  eot_q;
	logic [FW-1:0]         fill_q;
	logic [FW-1:0]         idx_q;
	logic [AW-1:0]         idx_s1;
	logic                  look_s1;
	logic                  hit_q;
	logic [AW-1:0]         slot_q;
	logic [COUNT_BITS-1:0] cnt_q;
	status_t               stat_q;

	// Result register.
	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [9:0]            slot_out_q;
	logic [31:0]           occ_q;
	logic [KEY_BITS-1:0]   chars_q;
	logic [4:0]            wlen_out_q;

	// Token row of character cells.
	cell_ctl_t     ctl;
	logic [SLOTS:0] ptr;
	logic [7:0]    chars [SLOTS];

	logic acc, is_end, fin, append;

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;
	assign is_end   = (kind == KIND_END);
	assign fin      = acc && (is_end || is_space(text_byte));
	assign append   = acc && !fin && !ovf_q && (len_q < LW'(SLOTS));

	assign ctl.clear = fin;
	assign ctl.load  = append;
	assign ctl.data  = text_byte;
	assign ptr[0]    = 1'b0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		wft_cell #(.HEAD(i == 0)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.ptr_in   (ptr[i]),
			.ptr_out  (ptr[i+1]),
			.char_out (chars[i])
		);
	end

	// Filters applied when a token closes.
	logic          strip;
	logic          bad;
	logic [LW-1:0] nlen;
	logic          keep;

	assign strip = is_strip(last_q);
	assign bad   = inner_bad_q || (!strip && !is_alnum(last_q));
	assign nlen  = len_q - LW'(strip);
	assign keep  = (len_q != '0) && !ovf_q && !dot_q && !bad && (nlen != '0) &&
		(nlen <= LW'(MAX_WORD_CHARS)) && is_letter(chars[0]);

	// Key: kept characters in order, zero beyond the word's length.
	logic [KEY_BITS-1:0] key;
	for (genvar k = 0; k < KEY_CHARS; k++) begin : g_key
		if (k < SLOTS) begin : g_used
			assign key[8*k +: 8] = (LW'(k) < nlen) ? chars[k] : 8'h00;
		end else begin : g_pad
			assign key[8*k +: 8] = 8'h00;
		end
	end

	// Table memory, each row holding {key, count}.
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr;
	logic [RW-1:0] ram_wdata, ram_rdata;
	logic          room, match;
	logic [COUNT_BITS-1:0] rd_cnt, rd_inc;

	assign room      = (fill_q < FW'(TABLE_ENTRIES));
	assign ram_re    = (state_q == S_SCAN) && (idx_q < fill_q) && !match;
	assign ram_we    = (state_q == S_WRITE) && (hit_q || room);
	assign ram_waddr = hit_q ? slot_q : AW'(fill_q);
	assign ram_wdata = {key_q, hit_q ? cnt_q : COUNT_BITS'(1)};
	assign rd_cnt    = ram_rdata[COUNT_BITS-1:0];
	assign rd_inc    = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
	assign match     = look_s1 && (ram_rdata[RW-1:COUNT_BITS] == key_q);

	wft_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (AW'(idx_q)),
		.rdata (ram_rdata)
	);

	// Token bookkeeping, following each text byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			ovf_q       <= 1'b0;
			dot_q       <= 1'b0;
			inner_bad_q <= 1'b0;
		end else if (fin) begin
			len_q       <= '0;
			ovf_q       <= 1'b0;
			dot_q       <= 1'b0;
			inner_bad_q <= 1'b0;
		end else if (acc) begin
			if (text_byte == 8'h2e) begin
				dot_q <= 1'b1;
			end
			if (!ovf_q) begin
				if (len_q >= LW'(SLOTS)) begin
					ovf_q <= 1'b1;
				end else begin
					if (len_q != '0 && !is_alnum(last_q)) begin
						inner_bad_q <= 1'b1;
					end
					len_q <= len_q + LW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (append) begin
			last_q <= text_byte;
		end
		if (fin && keep) begin
			key_q  <= key;
			wlen_q <= nlen;
			eot_q  <= is_end;
		end
	end

	// Lookup sequencer: scan the filled entries, then update, append or drop the word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			idx_q       <= '0;
			look_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// In the done state the result register is reloaded below instead.
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (fin && keep) begin
						idx_q   <= '0;
						look_s1 <= 1'b0;
						state_q <= S_SCAN;
					end else if (fin && is_end) begin
						fill_q <= '0;
					end
				end
				S_SCAN: begin
					if (match) begin
						look_s1 <= 1'b0;
						state_q <= S_WRITE;
					end else if (idx_q < fill_q) begin
						look_s1 <= 1'b1;
						idx_q   <= idx_q + FW'(1);
					end else if (look_s1) begin
						look_s1 <= 1'b0;
					end else begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (!hit_q && room) begin
						fill_q <= fill_q + FW'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						if (eot_q) begin
							fill_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Lookup payload.
	always_ff @(posedge clk) begin
		if (ram_re) begin
			idx_s1 <= AW'(idx_q);
		end
		case (state_q)
			S_IDLE: begin
				hit_q <= 1'b0;
			end
			S_SCAN: begin
				if (match) begin
					hit_q  <= 1'b1;
					slot_q <= idx_s1;
					cnt_q  <= rd_inc;
				end
			end
			S_WRITE: begin
				if (hit_q) begin
					stat_q <= ST_HIT;
				end else if (room) begin
					stat_q <= ST_NEW;
					slot_q <= AW'(fill_q);
					cnt_q  <= COUNT_BITS'(1);
				end else begin
					stat_q <= ST_DROP;
					slot_q <= '0;
					cnt_q  <= '0;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					status_q   <= stat_q;
					slot_out_q <= 10'(slot_q);
					occ_q      <= 32'(cnt_q);
					chars_q    <= key_q;
					wlen_out_q <= 5'(wlen_q);
				end
			end
			default: begin
				hit_q <= 1'b0;
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign slot        = slot_out_q;
	assign occurrences = occ_q;
	assign chars_low   = chars_q[63:0];
	assign chars_mid   = chars_q[127:64];
	assign chars_high  = chars_q[191:128];
	assign char_last   = chars_q[199:192];
	assign word_length = wlen_out_q;
endmodule
`default_nettype wire

/* rtl/wft_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module wft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

/* rtl/wft_cell.sv */
// One character cell of the token row: holds a byte and passes the write pointer on.
`default_nettype none
module wft_cell #(
	parameter bit HEAD = 1'b0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wft_pkg::cell_ctl_t ctl,
	input  wire logic              ptr_in,
	output logic                   ptr_out,
	output logic [7:0]             char_out
);
	import wft_pkg::*;

	logic       ptr_q;
	logic [7:0] char_q;

	// The pointer marks the cell that takes the next character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= HEAD;
		end else if (ctl.clear) begin
			ptr_q <= HEAD;
		end else if (ctl.load) begin
			ptr_q <= ptr_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load && ptr_q) begin
			char_q <= ctl.data;
		end
	end

	assign ptr_out  = ptr_q;
	assign char_out = char_q;
endmodule
`default_nettype wire

/* rtl/wft_checker.sv */
// Port-level checker for the word frequency table and its bind statement.
`default_nettype none
module wft_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  status,
	input wire logic [9:0]  slot,
	input wire logic [31:0] occurrences,
	input wire logic [4:0]  word_length
);
	import wft_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(occurrences))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_HIT || status == ST_NEW || status == ST_DROP))
		else $error("bad status code");

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DROP |-> slot == '0 && occurrences == '0)
		else $error("dropped word carries slot or count");

	a_new_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NEW |-> occurrences == 32'd1)
		else $error("new entry count is not one");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> word_length != '0)
		else $error("empty word reported");
endmodule

bind word_frequency_table wft_checker u_wft_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.slot        (slot),
	.occurrences (occurrences),
	.word_length (word_length)
);
`default_nettype wire

/* bench/wft_checker.sv */
// Checker for the word frequency table: watches both channels, predicts results, compares.
module wft_tb_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic        kind,
	input  wire logic [7:0]  text_byte,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [1:0]  status,
	input  wire logic [9:0]  slot,
	input  wire logic [31:0] occurrences,
	input  wire logic [63:0] chars_low,
	input  wire logic [63:0] chars_mid,
	input  wire logic [63:0] chars_high,
	input  wire logic [7:0]  char_last,
	input  wire logic [4:0]  word_length,
	output int               errors,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import wft_pkg::*;

	localparam int ENTRIES = 1024;
	localparam int TOKEN_SLOTS = 26;

	typedef struct packed {
		status_t     st;
		logic [9:0]  idx;
		logic [31:0] occ;
		logic [199:0] key;
		logic [4:0]  len;
	} word_result_t;

	word_result_t word_results[$];

	logic [7:0]   tok[TOKEN_SLOTS];
	int           tok_len;
	bit           tok_over, tok_dot, tok_bad;
	logic [199:0] keys[ENTRIES];
	logic [31:0]  counts[ENTRIES];
	int           fill;

	assign pending = word_results.size();

	function automatic bit letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit alnum(logic [7:0] c);
		return letter(c) || (c >= "0" && c <= "9");
	endfunction

	function automatic bit strip_char(logic [7:0] c);
		return c == ":" || c == "!" || c == "," || c == "." || c == "?" ||
			c == ")" || c == 8'h22;
	endfunction

	// Closes the pending token and queues the result of a kept word.
	task automatic close_word();
		int n, i, hit;
		bit bad;
		logic [199:0] key;
		word_result_t r;
		n = tok_len;
		bad = tok_bad;
		key = '0;
		if (n == 0 || tok_over || tok_dot) return;
		if (strip_char(tok[n-1])) n--;
		else if (!alnum(tok[n-1])) bad = 1;
		if (n == 0 || n > 25 || bad || !letter(tok[0])) return;
		for (i = 0; i < n; i++) key[8*i +: 8] = tok[i];
		hit = -1;
		for (i = 0; i < fill; i++)
			if (keys[i] == key) begin
				hit = i;
				break;
			end
		r.key = key;
		r.len = n[4:0];
		if (hit >= 0) begin
			if (counts[hit] != 32'hffff_ffff) counts[hit]++;
			r.st = ST_HIT;
			r.idx = hit[9:0];
			r.occ = counts[hit];
		end else if (fill < ENTRIES) begin
			keys[fill] = key;
			counts[fill] = 1;
			r.st = ST_NEW;
			r.idx = fill[9:0];
			r.occ = 1;
			fill++;
		end else begin
			r.st = ST_DROP;
			r.idx = '0;
			r.occ = '0;
		end
		word_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		word_result_t e;
		if (!arst_n) begin
			tok_len = 0; tok_over = 0; tok_dot = 0; tok_bad = 0; fill = 0;
			errors = 0;
			word_results.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (word_results.size() == 0) begin
					$error("unexpected result beat");
					errors++;
				end else begin
					e = word_results.pop_front();
					if (status != e.st) begin
						$error("status exp %0d got %0d", e.st, status); errors++;
					end
					if (slot != e.idx) begin
						$error("slot exp %0d got %0d", e.idx, slot); errors++;
					end
					if (occurrences != e.occ) begin
						$error("occurrences exp %0d got %0d", e.occ, occurrences); errors++;
					end
					if (chars_low != e.key[63:0]) begin
						$error("chars_low exp %h got %h", e.key[63:0], chars_low); errors++;
					end
					if (chars_mid != e.key[127:64]) begin
						$error("chars_mid exp %h got %h", e.key[127:64], chars_mid); errors++;
					end
					if (chars_high != e.key[191:128]) begin
						$error("chars_high exp %h got %h", e.key[191:128], chars_high);
						errors++;
					end
					if (char_last != e.key[199:192]) begin
						$error("char_last exp %h got %h", e.key[199:192], char_last); errors++;
					end
					if (word_length != e.len) begin
						$error("word_length exp %0d got %0d", e.len, word_length); errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (kind == KIND_END || text_byte == 8'd32 ||
					(text_byte >= 8'd9 && text_byte <= 8'd13)) begin
					close_word();
					tok_len = 0; tok_over = 0; tok_dot = 0; tok_bad = 0;
					if (kind == KIND_END) fill = 0;
				end else begin
					if (text_byte == ".") tok_dot = 1;
					if (!tok_over) begin
						if (tok_len >= TOKEN_SLOTS) tok_over = 1;
						else begin
							if (tok_len > 0 && !alnum(tok[tok_len-1])) tok_bad = 1;
							tok[tok_len] = text_byte;
							tok_len++;
						end
					end
				end
			end
		end
	end
endmodule

/* bench/tb_word_frequency_table.sv */
// Testbench top for the word frequency table: stimulus, idling phases and verdict.
module tb_word_frequency_table;
	timeunit 1ns;
	timeprecision 1ps;
	import wft_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic        kind = KIND_BYTE;
	logic [7:0]  text_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 0;
	logic [1:0]  status;
	logic [9:0]  slot;
	logic [31:0] occurrences;
	logic [63:0] chars_low, chars_mid, chars_high;
	logic [7:0]  char_last;
	logic [4:0]  word_length;
	int          errors, pending;
	int          send_idle_pct, recv_idle_pct;
	int          beats_sent;

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	word_frequency_table dut (.*);

	wft_tb_checker u_checker (.*);

	// The receiver stalls at random according to the current phase.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Sends one beat: optional idle gap first, then hold valid until accepted.
	// Valid stays high after the beat so that beats can follow back to back.
	task automatic send_beat(logic k, logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		text_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic send_text(string s);
		foreach (s[i]) send_beat(KIND_BYTE, s[i]);
	endtask

	// A word from a small vocabulary so that repeats and hits are common.
	function automatic string vocab_word();
		string w;
		int n;
		n = $urandom_range(3) == 0 ? $urandom_range(26, 1) : $urandom_range(4, 1);
		w = "";
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(4))
				0: w = {w, "A"};
				1: w = {w, "b"};
				2: w = {w, "Z"};
				3: w = {w, (i == 0) ? "z" : "9"};
				default: w = {w, "a"};
			endcase
		end
		return w;
	endfunction

	function automatic logic [7:0] space_char();
		logic [7:0] sp[6] = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
		return sp[$urandom_range(5)];
	endfunction

	function automatic logic [7:0] tail_char();
		logic [7:0] tl[7] = '{":", "!", ",", ".", "?", ")", 8'h22};
		return tl[$urandom_range(6)];
	endfunction

	// Mostly well-formed words with random content; the rest is noise or end of text.
	task automatic random_chunk();
		int sel;
		sel = $urandom_range(99);
		if (sel < 70) begin
			send_text(vocab_word());
			if ($urandom_range(3) == 0) send_beat(KIND_BYTE, tail_char());
			send_beat(KIND_BYTE, space_char());
		end else if (sel < 90) begin
			send_beat(KIND_BYTE, 8'($urandom_range(255)));
		end else if (sel < 98) begin
			for (int i = 0; i < $urandom_range(12, 1); i++)
				send_beat(KIND_BYTE, 8'($urandom));
			send_beat(KIND_BYTE, space_char());
		end else begin
			send_beat(KIND_END, 8'($urandom));
		end
	endtask

	// Drops valid, then waits until every expected result has come.
	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (1100) @(posedge clk);
	endtask

	initial begin
		#2_000_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		send_idle_pct = 16;
		recv_idle_pct = 52;
		beats_sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: plain word, repeat, strips, dot, overlong, bad chars.
		send_text("Hello Hello, x9: 9ab a.b ");
		send_text("Abcdefghijklmnopqrstuvwxy) ");
		send_text("Abcdefghijklmnopqrstuvwxyz ! a-b ab\xff \"q\" ");
		send_beat(KIND_BYTE, 8'd9);
		send_text("end");
		send_beat(KIND_END, 8'hff);
		send_beat(KIND_END, 8'h00);
		send_text("Hello");
		send_beat(KIND_BYTE, 8'd13);

		// The sender waits here until every result is back.
		drain();

		// A run of distinct words that grows the table, then end of text.
		for (int i = 0; i < 60; i++) begin
			send_beat(KIND_BYTE, "w");
			send_beat(KIND_BYTE, 8'("a" + i % 26));
			send_beat(KIND_BYTE, 8'("a" + (i / 26) % 26));
			send_beat(KIND_BYTE, 8'("A" + i / 676));
			send_beat(KIND_BYTE, space_char());
		end
		send_beat(KIND_END, 8'h00);
		drain();

		beats_sent = 0;
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 52 : 0;
			recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 16 : 0;
			while (beats_sent < 420 * (phase + 1)) random_chunk();
		end
		send_beat(KIND_END, 8'h00);
		drain();

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

/* files.f */
rtl/wft_pkg.sv
rtl/wft_ram.sv
rtl/wft_cell.sv
rtl/word_frequency_table.sv
rtl/wft_checker.sv
bench/wft_checker.sv
bench/tb_word_frequency_table.sv
